@@ src/kfrk_pkg.sv @@
// Shared types and codes for the keyed FIFO with remove-by-key.
package kfrk_pkg;

   // Command carried in the request tuser bit
   localparam logic CMD_ENTER = 1'b0;
   localparam logic CMD_LEAVE = 1'b1;

   // Capacity register index and reset value
   localparam int unsigned REG_CAPACITY = 0;
   localparam logic [4:0]  CAPACITY_RESET = 5'd10;

   typedef enum logic [2:0] {
      ST_ENTERED   = 3'd0,
      ST_FULL      = 3'd1,
      ST_DUPLICATE = 3'd2,
      ST_REMOVED   = 3'd3,
      ST_NOT_FOUND = 3'd4
   } kfrk_status_type;

   typedef struct packed {
      kfrk_status_type status;
      logic [4:0]      cars_ahead;
      logic [4:0]      cars_behind;
      logic [4:0]      occupancy;
   } kfrk_result_type;

endpackage

@@ src/keyed_fifo_with_remove_by_key_core.sv @@
// Top level of the keyed FIFO with remove-by-key: stream ports, register port, output stage.
//
//   channel  direction  handshake                 payload
//   req      in         req_tvalid / req_tready   tuser command, tdata plate_key
//   rsp      out        rsp_tvalid / rsp_tready   tuser status, tdata counts
//   csr      in         psel/penable/pwrite       capacity at byte address 0
//
// Steps: an item is captured, the key store is scanned, and the result is
// posted; a removal also closes the gap after the scan, which reads each
// later slot and rewrites it one place forward on the following cycle,
// overlapped with the next read.
// The store's one read port sets the pace.
// Reset: synchronous, active high; clears occupancy and sets capacity to 10.
// The key store is not cleared; slots are read only after being written.
// Stalls: a finished result waits in the output register while the next
// request is captured and scanned; if that register is still full when the
// next result is ready, the sequencer holds it and takes no new request.
module keyed_fifo_with_remove_by_key_core import kfrk_pkg::*; #(
   parameter int DEPTH     = 16,
   parameter int KEY_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] plate_key
   input  logic [0:0]  req_tuser,   // [0] command
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [4:0] cars_ahead, [9:5] cars_behind,
                                    // [14:10] occupancy, [15] zero
   output logic [2:0]  rsp_tuser,   // [2:0] status
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AW    = $clog2(DEPTH);
   localparam int KW_IN = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;

   logic [4:0]           capacity_ff, capacity_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   kfrk_result_type      rsp_data_ff, rsp_data_in;

   logic [KEY_WIDTH-1:0] key;
   logic                 res_valid;
   logic                 res_ready;
   kfrk_result_type      res;
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   logic [KEY_WIDTH-1:0] mem_wdata;
   logic [AW-1:0]        mem_raddr;
   logic [KEY_WIDTH-1:0] mem_rdata;
   logic                 csr_write;
   logic                 csr_hit;

   // Keep only the key bits the store holds; widen with zeros where wider.
   assign key = KEY_WIDTH'(req_tdata[KW_IN-1:0]);

   // Register port: one register, word index taken from paddr[2].
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == REG_CAPACITY[0]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_hit ? {27'd0, capacity_ff} : 32'd0;

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_write && csr_hit) begin
         capacity_in = csr_pwdata[4:0];
      end
   end

   // Output register: load a result when empty or being drained this cycle.
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.status;
   assign rsp_tdata  = {1'b0, rsp_data_ff.occupancy, rsp_data_ff.cars_behind,
                        rsp_data_ff.cars_ahead};

   kfrk_ctrl #(
      .DEPTH     (DEPTH),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_cmd    (req_tuser[0]),
      .in_key    (key),
      .capacity  (capacity_ff),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   kfrk_key_ram #(
      .DEPTH (DEPTH),
      .WIDTH (KEY_WIDTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

endmodule

@@ src/kfrk_key_ram.sv @@
// Key store: one write port, one read port with registered read data.
module kfrk_key_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/kfrk_ctrl.sv @@
// Sequencer: scans the key store through one comparator, appends, and closes gaps.
module kfrk_ctrl import kfrk_pkg::*; #(
   parameter int DEPTH     = 16,
   parameter int KEY_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic                       in_cmd,
   input  logic [KEY_WIDTH-1:0]       in_key,
   input  logic [4:0]                 capacity,
   output logic                       res_valid,
   input  logic                       res_ready,
   output kfrk_result_type            res,
   output logic                       mem_we,
   output logic [$clog2(DEPTH)-1:0]   mem_waddr,
   output logic [KEY_WIDTH-1:0]       mem_wdata,
   output logic [$clog2(DEPTH)-1:0]   mem_raddr,
   input  logic [KEY_WIDTH-1:0]       mem_rdata
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > 5) ? CW : 5;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_RESP
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   scan_ff, scan_in;
   logic            pend_ff, pend_in;
   logic [AW-1:0]   pend_idx_ff, pend_idx_in;
   logic [AW-1:0]   pos_ff, pos_in;
   logic            cmd_ff, cmd_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   kfrk_result_type res_ff, res_in;

   logic          hit;
   logic          more;
   logic          full;
   logic [CW-1:0] count_inc;
   logic [CW-1:0] count_dec;

   assign hit       = pend_ff && (mem_rdata == key_ff);
   assign more      = scan_ff < count_ff;
   assign full      = (count_ff >= CW'(DEPTH)) || (CMPW'(count_ff) >= CMPW'(capacity));
   assign count_inc = count_ff + CW'(1);
   assign count_dec = count_ff - CW'(1);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      scan_in     = scan_ff;
      pend_in     = 1'b0;
      pend_idx_in = pend_idx_ff;
      pos_in      = pos_ff;
      cmd_in      = cmd_ff;
      key_in      = key_ff;
      res_in      = res_ff;
      mem_we      = 1'b0;
      mem_waddr   = pend_idx_ff - AW'(1);
      mem_wdata   = mem_rdata;
      mem_raddr   = scan_ff[AW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               cmd_in   = in_cmd;
               key_in   = in_key;
               scan_in  = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (hit || !more) begin
               res_in.cars_ahead  = '0;
               res_in.cars_behind = '0;
               res_in.occupancy   = 5'(count_ff);
               state_in           = S_RESP;
               if (cmd_ff == CMD_ENTER) begin
                  if (hit) begin
                     res_in.status = ST_DUPLICATE;
                  end else if (full) begin
                     res_in.status = ST_FULL;
                  end else begin
                     mem_we           = 1'b1;
                     mem_waddr        = count_ff[AW-1:0];
                     mem_wdata        = key_ff;
                     count_in         = count_inc;
                     res_in.status    = ST_ENTERED;
                     res_in.occupancy = 5'(count_inc);
                  end
               end else if (hit) begin
                  // start closing the gap from the slot behind the hit
                  pos_in   = pend_idx_ff;
                  scan_in  = CW'(pend_idx_ff) + CW'(1);
                  state_in = S_SHIFT;
               end else begin
                  res_in.status = ST_NOT_FOUND;
               end
            end else begin
               pend_in     = 1'b1;
               pend_idx_in = scan_ff[AW-1:0];
               scan_in     = scan_ff + CW'(1);
            end
         end
         S_SHIFT: begin
            // write the slot read last cycle one place forward
            mem_we = pend_ff;
            if (more) begin
               pend_in     = 1'b1;
               pend_idx_in = scan_ff[AW-1:0];
               scan_in     = scan_ff + CW'(1);
            end else begin
               count_in           = count_dec;
               res_in.status      = ST_REMOVED;
               res_in.cars_ahead  = 5'(pos_ff);
               res_in.cars_behind = 5'(count_dec - CW'(pos_ff));
               res_in.occupancy   = 5'(count_dec);
               state_in           = S_RESP;
            end
         end
         S_RESP: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
      scan_ff     <= scan_in;
      pend_idx_ff <= pend_idx_in;
      pos_ff      <= pos_in;
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      res_ff      <= res_in;
   end

   assign in_ready  = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_RESP);
   assign res       = res_ff;

endmodule

@@ src/kfrk_checker.sv @@
// Port-level checks for the keyed FIFO with remove-by-key, bound to the top level.
module kfrk_checker import kfrk_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // an accepted request keeps the block busy on the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous one in work");

   // only removals report keys ahead or behind
   a_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_REMOVED) |-> rsp_tdata[9:0] == 10'd0)
      else $error("nonzero position counts on non-removal");

   // status codes stay within the defined set, pad bit stays clear
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser <= ST_NOT_FOUND) && !rsp_tdata[15])
      else $error("bad status or pad bit");

endmodule

bind keyed_fifo_with_remove_by_key_core kfrk_checker u_kfrk_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
